>>> rtl/core/ogls_pkg.sv
// ----------------------------------------------------------------------------
// ogls_pkg
// Shared types, constants and codes for the objective grid leader select core.
// ----------------------------------------------------------------------------
package ogls_pkg;

  // Grid geometry
  localparam int GRID_SIDE = 16;
  localparam int IDX_W     = 4;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = 2 * IDX_W;

  // Field widths
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 16;
  localparam int CROWD_W   = 18;
  localparam int RND_W     = 16;
  localparam int EDGE_W    = VAL_W + IDX_W + 1;
  localparam int TIE_W     = $clog2(CELLS + 1);
  localparam int SCAN_W    = $clog2(CELLS + GRID_SIDE);
  localparam int STEP_W    = $clog2(RND_W);

  // Last scan address: the row below the last centre cell has been read
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CELLS + GRID_SIDE - 1);

  // Function codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_QUERY  = 2'd1;
  localparam logic [1:0] FN_SELECT = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOWER_F1 = 2'd0;
  localparam logic [1:0] CFG_WIDTH_F1 = 2'd1;
  localparam logic [1:0] CFG_LOWER_F2 = 2'd2;
  localparam logic [1:0] CFG_WIDTH_F2 = 2'd3;

  typedef enum logic [2:0] {
    RES_CELL,
    RES_OUTSIDE,
    RES_EMPTY,
    RES_CLEAR,
    RES_LEADER
  } res_kind_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [VAL_W-1:0] first_objective;
    logic [VAL_W-1:0] second_objective;
    logic [RND_W-1:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   column_index;
    logic [CNT_W-1:0]   cell_count;
    logic [CROWD_W-1:0] crowding_count;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              bin_step;
    logic [STEP_W-1:0] bin_bit;
    logic              cell_read;
    logic              cell_update;
    logic              scan_issue;
    logic [SCAN_W-1:0] scan_addr;
    logic              scan_first;
    logic              scan_pass;
    logic              mod_init;
    logic              mod_step;
    logic              clear_grid;
    logic              res_load;
    res_kind_t         res_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic outside;
    logic ties_zero;
  } stat_t;

endpackage

>>> rtl/core/ogls_ram.sv
// ----------------------------------------------------------------------------
// ogls_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ogls_datapath.sv
// ----------------------------------------------------------------------------
// ogls_datapath
// Config registers, bin dividers, count store, scan window and tie logic.
// ----------------------------------------------------------------------------
module ogls_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  ogls_pkg::in_word_t      operand,
  input  ogls_pkg::cmd_t          cmd,
  output ogls_pkg::stat_t         stat,
  output ogls_pkg::out_word_t     result
);
  import ogls_pkg::*;

  // Config registers
  logic [VAL_W-1:0] lower_f1, width_f1, lower_f2, width_f2;

  // Latched operation
  logic [1:0]       func_q;
  logic [RND_W-1:0] div_q;

  // Bin division lanes
  logic [VAL_W-1:0]  d1, d2, w1, w2;
  logic              below1, below2;
  logic [EDGE_W-1:0] acc1, acc2;
  logic [IDX_W-1:0]  q1, q2;
  logic [EDGE_W-1:0] trial1, trial2, edge1, edge2;
  logic              inside1, inside2;
  logic [IDX_W-1:0]  bin1, bin2;
  logic [ADDR_W-1:0] cell_idx;

  // Count store
  logic              vld [CELLS];
  logic              rd_vld;
  logic [CNT_W-1:0]  rdata, cnt_rd, new_count;
  logic              we;
  logic [ADDR_W-1:0] raddr;

  // Scan window
  logic              p_valid, p_inrange, p_pass;
  logic [SCAN_W-1:0] p_addr;
  logic [CNT_W-1:0]  sh [2*GRID_SIDE];
  logic [CNT_W-1:0]  cnt_in, centre;
  logic [CROWD_W-1:0] crowd, best;
  logic [ADDR_W-1:0] centre_idx;
  logic              eval;
  logic [TIE_W-1:0]  ties, rem, k, t_rem;
  logic              found;
  out_word_t         leader;
  out_word_t         res_next;

  // Bin results
  always_comb begin
    trial1  = acc1 + (EDGE_W'(w1) << cmd.bin_bit);
    trial2  = acc2 + (EDGE_W'(w2) << cmd.bin_bit);
    edge1   = EDGE_W'(w1) * EDGE_W'(GRID_SIDE);
    edge2   = EDGE_W'(w2) * EDGE_W'(GRID_SIDE);
    inside1 = !below1 && (EDGE_W'(d1) <= edge1);
    inside2 = !below2 && (EDGE_W'(d2) <= edge2);
    bin1    = (EDGE_W'(d1) == edge1) ? IDX_W'(GRID_SIDE - 1) : q1;
    bin2    = (EDGE_W'(d2) == edge2) ? IDX_W'(GRID_SIDE - 1) : q2;
    cell_idx = {bin1, bin2};
  end

  assign stat.outside   = !(inside1 && inside2);
  assign stat.ties_zero = (ties == '0);

  // Store access
  assign cnt_rd    = rd_vld ? rdata : '0;
  assign new_count = (func_q == FN_INSERT && cnt_rd != '1) ? cnt_rd + 1'b1 : cnt_rd;
  assign we        = cmd.cell_update && (func_q == FN_INSERT);
  assign raddr     = cmd.scan_issue ? cmd.scan_addr[ADDR_W-1:0] : cell_idx;

  ogls_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (cell_idx),
    .wdata (new_count),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Crowding of the centre cell: above, centre, below in one column
  always_comb begin
    cnt_in     = p_inrange ? cnt_rd : '0;
    centre     = sh[GRID_SIDE-1];
    crowd      = CROWD_W'(centre) + CROWD_W'(sh[2*GRID_SIDE-1]) + CROWD_W'(cnt_in);
    centre_idx = ADDR_W'(p_addr - SCAN_W'(GRID_SIDE));
    eval       = p_valid && (p_addr >= SCAN_W'(GRID_SIDE)) && (centre != '0);
    t_rem      = {rem[TIE_W-2:0], div_q[RND_W-1]};
  end

  // Result word for the operation that finishes
  always_comb begin
    res_next = '0;
    case (cmd.res_kind)
      RES_CELL: begin
        res_next.status       = ST_OK;
        res_next.row_index    = bin1;
        res_next.column_index = bin2;
        res_next.cell_count   = new_count;
      end
      RES_OUTSIDE: res_next.status = ST_OUTSIDE;
      RES_EMPTY:   res_next.status = ST_EMPTY;
      RES_LEADER:  res_next = leader;
      default:     res_next.status = ST_OK;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_f1 <= '0;
      width_f1 <= 32'd65536;
      lower_f2 <= '0;
      width_f2 <= 32'd65536;
      for (int i = 0; i < CELLS; i++) vld[i] <= 1'b0;
      p_valid  <= 1'b0;
      found    <= 1'b0;
      ties     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOWER_F1: lower_f1 <= cfg_data;
          CFG_WIDTH_F1: width_f1 <= cfg_data;
          CFG_LOWER_F2: lower_f2 <= cfg_data;
          CFG_WIDTH_F2: width_f2 <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_grid) begin
        for (int i = 0; i < CELLS; i++) vld[i] <= 1'b0;
      end else if (we) begin
        vld[cell_idx] <= 1'b1;
      end
      p_valid <= cmd.scan_issue;
      // tie counting on the first pass, k-th match on the second
      if (cmd.scan_issue && cmd.scan_first) begin
        if (!cmd.scan_pass) ties <= '0;
        else found <= 1'b0;
      end else if (eval && !p_pass) begin
        if (crowd < best) ties <= TIE_W'(1);
        else if (crowd == best) ties <= ties + 1'b1;
      end else if (eval && p_pass && crowd == best && !found && k == '0) begin
        found <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    if (cmd.load) begin
      func_q <= operand.func;
      div_q  <= operand.random_value;
      d1     <= operand.first_objective - lower_f1;
      d2     <= operand.second_objective - lower_f2;
      below1 <= operand.first_objective < lower_f1;
      below2 <= operand.second_objective < lower_f2;
      w1     <= (width_f1 == '0) ? VAL_W'(1) : width_f1;
      w2     <= (width_f2 == '0) ? VAL_W'(1) : width_f2;
      acc1   <= '0;
      acc2   <= '0;
      q1     <= '0;
      q2     <= '0;
    end
    // one quotient bit per lane per step
    if (cmd.bin_step) begin
      if (trial1 <= EDGE_W'(d1)) begin
        acc1 <= trial1;
        q1[cmd.bin_bit[$clog2(IDX_W)-1:0]] <= 1'b1;
      end
      if (trial2 <= EDGE_W'(d2)) begin
        acc2 <= trial2;
        q2[cmd.bin_bit[$clog2(IDX_W)-1:0]] <= 1'b1;
      end
    end
    // random mod tie count, one bit a step
    if (cmd.mod_init) begin
      rem <= '0;
    end else if (cmd.mod_step) begin
      div_q <= div_q << 1;
      rem   <= (t_rem >= ties) ? t_rem - ties : t_rem;
    end
    // scan window
    if (cmd.scan_issue) begin
      p_addr    <= cmd.scan_addr;
      p_inrange <= cmd.scan_addr < SCAN_W'(CELLS);
      p_pass    <= cmd.scan_pass;
    end
    if (cmd.scan_issue && cmd.scan_first) begin
      for (int i = 0; i < 2*GRID_SIDE; i++) sh[i] <= '0;
      if (!cmd.scan_pass) best <= '1;
      else k <= rem;
    end else if (p_valid) begin
      sh[0] <= cnt_in;
      for (int i = 1; i < 2*GRID_SIDE; i++) sh[i] <= sh[i-1];
      if (eval && !p_pass && crowd < best) best <= crowd;
      if (eval && p_pass && crowd == best && !found) begin
        if (k == '0) begin
          leader.status         <= ST_OK;
          leader.row_index      <= centre_idx[ADDR_W-1:IDX_W];
          leader.column_index   <= centre_idx[IDX_W-1:0];
          leader.cell_count     <= centre;
          leader.crowding_count <= crowd;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
    // result word
    if (cmd.res_load) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/core/ogls_ctrl.sv
// ----------------------------------------------------------------------------
// ogls_ctrl
// Operation sequencer: bin division, cell update, two-pass leader scan.
// ----------------------------------------------------------------------------
module ogls_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      func,
  input  ogls_pkg::stat_t stat,
  output logic            busy,
  output logic            done,
  output ogls_pkg::cmd_t  cmd
);
  import ogls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BIN, S_LOOKUP, S_UPDATE, S_SCAN, S_DRAIN, S_DECIDE, S_MOD, S_FINISH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [SCAN_W-1:0] addr;
  logic              pass;

  assign busy = (state != S_IDLE);

  // Commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.res_kind   = RES_CELL;
    cmd.bin_bit    = step;
    cmd.scan_addr  = addr;
    cmd.scan_first = (addr == '0);
    cmd.scan_pass  = pass;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && func == FN_CLEAR) begin
          cmd.clear_grid = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_kind   = RES_CLEAR;
        end
      end
      S_BIN: cmd.bin_step = 1'b1;
      S_LOOKUP: begin
        cmd.cell_read = !stat.outside;
        cmd.res_load  = stat.outside;
        cmd.res_kind  = RES_OUTSIDE;
      end
      S_UPDATE: begin
        cmd.cell_update = 1'b1;
        cmd.res_load    = 1'b1;
      end
      S_SCAN: cmd.scan_issue = 1'b1;
      S_DECIDE: begin
        cmd.mod_init = !stat.ties_zero;
        cmd.res_load = stat.ties_zero;
        cmd.res_kind = RES_EMPTY;
      end
      S_MOD: cmd.mod_step = 1'b1;
      S_FINISH: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_LEADER;
      end
      default: ;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      step  <= '0;
      addr  <= '0;
      pass  <= 1'b0;
    end else begin
      done <= cmd.res_load;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (func)
              FN_INSERT, FN_QUERY: begin
                state <= S_BIN;
                step  <= STEP_W'(IDX_W - 1);
              end
              FN_SELECT: begin
                state <= S_SCAN;
                addr  <= '0;
                pass  <= 1'b0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_BIN: begin
          if (step == '0) state <= S_LOOKUP;
          else step <= step - 1'b1;
        end
        S_LOOKUP: state <= stat.outside ? S_IDLE : S_UPDATE;
        S_UPDATE: state <= S_IDLE;
        S_SCAN: begin
          if (addr == SCAN_LAST) state <= S_DRAIN;
          else addr <= addr + 1'b1;
        end
        S_DRAIN: state <= pass ? S_FINISH : S_DECIDE;
        S_DECIDE: begin
          if (stat.ties_zero) begin
            state <= S_IDLE;
          end else begin
            state <= S_MOD;
            step  <= STEP_W'(RND_W - 1);
          end
        end
        S_MOD: begin
          if (step == '0) begin
            state <= S_SCAN;
            addr  <= '0;
            pass  <= 1'b1;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_FINISH: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/objective_grid_leader_select_core.sv
// ----------------------------------------------------------------------------
// objective_grid_leader_select_core
// Adaptive grid of cell counts over two objectives with leader selection.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: operand is taken at a clock edge with start high and
//   busy low. One result word follows on result, marked by done for a
//   single cycle; the receiver cannot stall, so it must take it then.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while the core is idle.
// Sequence (start edge to done):
//   clear        valid bits cleared and result loaded as the command is taken
//   insert/query 4 bin division steps, store read, update; an operand
//                outside the grid ends at the store lookup.
//   select       two row-major scans over the single read port of the count
//                RAM, with a bit-serial random mod tie count between them.
//   One operation at a time; busy stays high until the result is loaded.
// Reset: rst clears the config registers to their defaults and the cell
//   valid bits, so the grid is empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
module objective_grid_leader_select_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ogls_pkg::in_word_t  operand,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output ogls_pkg::out_word_t result
);
  import ogls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ogls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (operand.func),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ogls_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operand   (operand),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // a result word only ends an accepted operation
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without an operation");

  // the core only goes busy on an accepted word
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // a chosen leader is populated and its crowding includes its own count
  a_leader_sane: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OK && result.crowding_count != '0) |->
      (result.cell_count != '0 &&
       result.crowding_count >= CROWD_W'(result.cell_count)))
    else $error("leader cell count inconsistent with crowding");
`endif

endmodule
